### hdl/rpra_pkg.sv
package rpra_pkg;

    typedef enum logic [1:0]
    {
        OP_TICK    = 2'd0,
        OP_REQUEST = 2'd1,
        OP_RELEASE = 2'd2,
        OP_STOP    = 2'd3
    } opcode_t;

    typedef enum logic [1:0]
    {
        REG_RANK_MODE = 2'd0,
        REG_BURNOUT   = 2'd1,
        REG_COOLDOWN  = 2'd2
    } reg_index_t;

    typedef enum logic [1:0]
    {
        ST_IDLE  = 2'd0,
        ST_SCAN  = 2'd1,
        ST_STOP  = 2'd2
    } state_t;

    localparam int unsigned ADDRESSABLE = 8;

    typedef struct packed
    {
        logic [1:0]  opcode;
        logic [2:0]  requester;
        logic [31:0] compile_start;
    } in_word_t;

    typedef struct packed
    {
        logic [2:0]  who;
        logic        granted;
        logic [31:0] grant_time;
        logic        last;
    } out_word_t;

    // Per-cell view handed from a cell to its neighbours
    typedef struct packed
    {
        logic        ready;
        logic        waiting;
        logic [31:0] deadline;
        logic [31:0] order;
    } cell_view_t;

    // Broadcast from the sequencer to every cell
    typedef struct packed
    {
        logic        do_request;
        logic        do_release;
        logic        do_grant;
        logic        do_refuse;
        logic [2:0]  sel;
        logic [31:0] deadline;
        logic [31:0] order;
        logic [31:0] free_at;
        logic [31:0] now;
        logic        by_deadline;
    } cell_ctrl_t;

endpackage

### hdl/rpra_cell.sv
module rpra_cell
    import rpra_pkg::*;
#(
    parameter int unsigned IDX = 0,
    parameter int unsigned N   = 8
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  cell_ctrl_t ctrl,
    input  logic       left_free,
    input  logic       right_free,
    input  cell_view_t prev_view,
    input  cell_view_t next_view,
    output logic       res_free,
    output cell_view_t view,
    output logic       can_take
);

    logic        taken_reg;
    logic [31:0] free_at_reg;
    logic        waiting_reg;
    logic [31:0] deadline_reg;
    logic [31:0] order_reg;
    logic        mine;
    logic        prev_sel;
    logic        prev_grant;
    logic        rel_hit;

    assign mine       = (32'(ctrl.sel) == IDX);
    // resource IDX is also the right resource of the previous requester
    assign prev_sel   = (32'(ctrl.sel) == (IDX + N - 1) % N);
    assign prev_grant = ctrl.do_grant && prev_sel;
    assign rel_hit    = ctrl.do_release && (mine || prev_sel);
    assign res_free   = !taken_reg && (ctrl.now >= free_at_reg);

    always_comb
    begin
        view.ready    = (N > 1) && left_free && right_free;
        view.waiting  = waiting_reg;
        view.deadline = deadline_reg;
        view.order    = order_reg;
    end

    function automatic logic beats(input cell_view_t a, input cell_view_t b, input logic edf);
        if (edf && a.deadline != b.deadline)
            return a.deadline < b.deadline;
        return a.order < b.order;
    endfunction

    always_comb
    begin
        can_take = waiting_reg && view.ready
            && (!prev_view.waiting || !prev_view.ready || (N == 1)
                || beats(view, prev_view, ctrl.by_deadline))
            && (!next_view.waiting || !next_view.ready || (N == 1)
                || beats(view, next_view, ctrl.by_deadline));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            taken_reg    <= 1'b0;
            free_at_reg  <= '0;
            waiting_reg  <= 1'b0;
            deadline_reg <= '0;
            order_reg    <= '0;
        end
        else
        begin
            if ((ctrl.do_grant && mine) || prev_grant)
                taken_reg <= 1'b1;
            else if (rel_hit)
                taken_reg <= 1'b0;
            // release frees resource IDX when IDX or its left neighbour releases
            if (rel_hit)
                free_at_reg <= ctrl.free_at;
            if (ctrl.do_request && mine)
            begin
                deadline_reg <= ctrl.deadline;
                order_reg    <= ctrl.order;
            end
            // a refusal wins over the request it answers
            if ((ctrl.do_grant || ctrl.do_refuse) && mine)
                waiting_reg <= 1'b0;
            else if (ctrl.do_request && mine)
                waiting_reg <= 1'b1;
        end
    end

endmodule

### hdl/ring_pair_resource_arbiter_top.sv
// After the accepting cycle the requesters are scanned one a cycle, in passes over
// min(NUM_REQUESTERS, 8) requesters, until a pass grants nothing; a stop adds a refusal
// pass and a closing scan state; once stopped a word only passes the closing one, and a
// refused request is answered in its accepting cycle. A result shows in the cycle after the
// next is decided or the word ends, the last as busy falls; results cannot stall. A
// word is taken only while idle. Reset (rst_n low, asynchronous) clears all but running.
module ring_pair_resource_arbiter_top
    import rpra_pkg::*;
#(
    parameter int unsigned NUM_REQUESTERS = 8
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  in_word_t    in_word,
    output logic        result_valid,
    output out_word_t   result,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int unsigned N   = NUM_REQUESTERS;
    localparam int unsigned LIM = (N < ADDRESSABLE) ? N : ADDRESSABLE;
    localparam int unsigned SW  = 3;

    logic        edf_reg;
    logic [15:0] burn_reg;
    logic [15:0] cool_reg;
    logic [31:0] now_reg, now_next;
    logic        running_reg, running_next;
    logic [31:0] ocnt_reg, ocnt_next;
    state_t      state_reg, state_next;
    logic [SW-1:0] idx_reg, idx_next;
    logic        hit_reg, hit_next;
    logic        pend_reg, pend_next;
    out_word_t   pend_word_reg, pend_word_next;
    logic        out_v_reg, out_v_next;
    out_word_t   out_reg, out_next;
    cell_ctrl_t  ctrl;
    logic [N-1:0] res_free;
    logic [N-1:0] can_take;
    cell_view_t  views [N];
    logic        emit;
    out_word_t   emit_word;
    logic        accept;
    logic        in_range;
    logic        refuse_now;
    logic        cur_take;
    logic        cur_wait;
    logic        word_done;

    assign pready = 1'b1;
    assign accept = start && !busy;
    assign busy   = (state_reg != ST_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            edf_reg  <= 1'b0;
            burn_reg <= '0;
            cool_reg <= '0;
        end
        else if (psel && penable && pwrite)
        begin
            case (reg_index_t'(paddr[3:2]))
                REG_RANK_MODE: edf_reg  <= pwdata[0];
                REG_BURNOUT:   burn_reg <= pwdata[15:0];
                REG_COOLDOWN:  cool_reg <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (reg_index_t'(paddr[3:2]))
            REG_RANK_MODE: prdata = {31'd0, edf_reg};
            REG_BURNOUT:   prdata = {16'd0, burn_reg};
            REG_COOLDOWN:  prdata = {16'd0, cool_reg};
            default:       prdata = '0;
        endcase
    end

    genvar g;
    generate
        for (g = 0; g < N; g++)
        begin : g_cell
            rpra_cell #(.IDX(g), .N(N)) u_cell
            (
                .clk         (clk),
                .rst_n       (rst_n),
                .ctrl        (ctrl),
                .left_free   (res_free[g]),
                .right_free  (res_free[(g + 1) % N]),
                .prev_view   (views[(g + N - 1) % N]),
                .next_view   (views[(g + 1) % N]),
                .res_free    (res_free[g]),
                .view        (views[g]),
                .can_take    (can_take[g])
            );
        end
    endgenerate

    assign in_range   = (32'(in_word.requester) < N);
    assign refuse_now = accept && in_range && !running_reg
                        && (opcode_t'(in_word.opcode) == OP_REQUEST);

    // pick out the cell under the scan pointer
    always_comb
    begin
        cur_take = 1'b0;
        cur_wait = 1'b0;
        for (int unsigned i = 0; i < LIM; i++)
        begin
            if (32'(idx_reg) == i)
            begin
                cur_take = can_take[i];
                cur_wait = views[i].waiting;
            end
        end
    end

    // next state
    always_comb
    begin
        state_next   = state_reg;
        idx_next     = idx_reg;
        hit_next     = hit_reg;
        now_next     = now_reg;
        running_next = running_reg;
        ocnt_next    = ocnt_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    idx_next = '0;
                    hit_next = 1'b0;
                    case (opcode_t'(in_word.opcode))
                        OP_TICK:    now_next = now_reg + 32'd1;
                        OP_REQUEST: if (in_range) ocnt_next = ocnt_reg + 32'd1;
                        OP_STOP:    running_next = 1'b0;
                        default: ;
                    endcase
                    // a refused request is answered at once and ends the word
                    if (refuse_now)
                        state_next = ST_IDLE;
                    else if (opcode_t'(in_word.opcode) == OP_STOP)
                        state_next = running_reg ? ST_STOP : ST_SCAN;
                    else
                        state_next = ST_SCAN;
                end
            end
            ST_STOP:
            begin
                idx_next = idx_reg + SW'(1);
                if (32'(idx_reg) == LIM - 1)
                begin
                    idx_next   = '0;
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (!running_reg)
                    state_next = ST_IDLE;
                else
                begin
                    if (cur_wait && cur_take)
                        hit_next = 1'b1;
                    idx_next = idx_reg + SW'(1);
                    if (32'(idx_reg) == LIM - 1)
                    begin
                        idx_next = '0;
                        hit_next = 1'b0;
                        if (!(hit_reg || (cur_wait && cur_take)))
                            state_next = ST_IDLE;
                    end
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // outputs to the cells and result stream
    always_comb
    begin
        ctrl                 = '0;
        ctrl.now             = now_reg;
        ctrl.by_deadline     = edf_reg;
        ctrl.deadline        = in_word.compile_start + 32'(burn_reg);
        ctrl.order           = ocnt_reg;
        ctrl.free_at         = now_reg + 32'(cool_reg);
        emit                 = 1'b0;
        emit_word            = '0;
        emit_word.grant_time = now_reg;
        case (state_reg)
            ST_IDLE:
            begin
                ctrl.sel = in_word.requester;
                if (accept && in_range)
                begin
                    ctrl.do_request = (opcode_t'(in_word.opcode) == OP_REQUEST);
                    ctrl.do_release = (opcode_t'(in_word.opcode) == OP_RELEASE);
                end
                if (refuse_now)
                begin
                    ctrl.do_refuse = 1'b1;
                    emit           = 1'b1;
                    emit_word.who  = in_word.requester;
                end
            end
            ST_STOP:
            begin
                ctrl.sel = idx_reg;
                if (cur_wait)
                begin
                    ctrl.do_refuse = 1'b1;
                    emit           = 1'b1;
                    emit_word.who  = idx_reg;
                end
            end
            ST_SCAN:
            begin
                ctrl.sel = idx_reg;
                if (running_reg && cur_wait && cur_take)
                begin
                    ctrl.do_grant     = 1'b1;
                    emit              = 1'b1;
                    emit_word.who     = idx_reg;
                    emit_word.granted = 1'b1;
                end
            end
            default: ;
        endcase
    end

    // hold one result back so the final one can carry last;
    // a scan never emits on the cycle that closes the word
    assign word_done = (state_reg != ST_IDLE) && (state_next == ST_IDLE);

    always_comb
    begin
        pend_next      = pend_reg;
        pend_word_next = pend_word_reg;
        out_v_next     = 1'b0;
        out_next       = pend_word_reg;
        if (state_reg == ST_IDLE)
        begin
            if (emit)
            begin
                out_v_next    = 1'b1;
                out_next      = emit_word;
                out_next.last = 1'b1;
            end
        end
        else
        begin
            if (pend_reg && (emit || word_done))
            begin
                out_v_next    = 1'b1;
                out_next.last = word_done;
            end
            if (emit)
            begin
                pend_next      = 1'b1;
                pend_word_next = emit_word;
            end
            else if (word_done)
                pend_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            idx_reg       <= '0;
            hit_reg       <= 1'b0;
            now_reg       <= '0;
            running_reg   <= 1'b1;
            ocnt_reg      <= '0;
            pend_reg      <= 1'b0;
            pend_word_reg <= '0;
            out_v_reg     <= 1'b0;
            out_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            idx_reg       <= idx_next;
            hit_reg       <= hit_next;
            now_reg       <= now_next;
            running_reg   <= running_next;
            ocnt_reg      <= ocnt_next;
            pend_reg      <= pend_next;
            pend_word_reg <= pend_word_next;
            out_v_reg     <= out_v_next;
            out_reg       <= out_next;
        end
    end

    assign result_valid = out_v_reg;
    assign result       = out_reg;

endmodule

### hdl/rpra_checker.sv
module rpra_checker
    import rpra_pkg::*;
(
    input logic      clk,
    input logic      rst_n,
    input logic      start,
    input logic      busy,
    input logic      result_valid,
    input out_word_t result
);

    a_result_known: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> !$isunknown(result))
        else $error("result word has unknown bits");

    a_start_answered: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> (busy || result_valid))
        else $error("accepted word neither raised busy nor answered");

    a_mid_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && !result.last) |-> busy)
        else $error("non-final result while idle");

    a_last_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result.last) |-> !busy)
        else $error("final result while busy");

endmodule

bind ring_pair_resource_arbiter_top rpra_checker u_rpra_checker
(
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .result_valid (result_valid),
    .result       (result)
);

### dv/ring_pair_resource_arbiter_top_tb.sv
module ring_pair_resource_arbiter_top_tb;
    import rpra_pkg::*;

    localparam int unsigned NREQ = 8;
    localparam int unsigned IDLE_LIMIT = 1000;
    localparam int unsigned RANDOM_WORDS = 400;

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    in_word_t    in_word;
    logic        result_valid;
    out_word_t   result;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [3:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    ring_pair_resource_arbiter_top #(.NUM_REQUESTERS(NREQ)) dut
    (
        .clk(clk),
        .rst_n(rst_n),
        .start(start),
        .busy(busy),
        .in_word(in_word),
        .result_valid(result_valid),
        .result(result),
        .psel(psel),
        .penable(penable),
        .pwrite(pwrite),
        .paddr(paddr),
        .pwdata(pwdata),
        .prdata(prdata),
        .pready(pready)
    );

    // predictor state
    logic        arb_edf;
    logic [31:0] arb_burnout;
    logic [31:0] arb_cooldown;
    logic [31:0] arb_now;
    logic        arb_running;
    logic        res_taken [NREQ];
    logic [31:0] res_free_at [NREQ];
    logic        req_waiting [NREQ];
    logic [31:0] req_deadline [NREQ];
    logic [31:0] req_seq [NREQ];
    logic [31:0] seq_counter;

    out_word_t   pending_grants [$];
    int unsigned fail_count;
    int unsigned idle_cycles;
    bit          allow_gaps;

    typedef struct
    {
        in_word_t  word;
        bit        has_check;
        out_word_t first_grant;
    } stim_row_t;

    function automatic int unsigned right_of(int unsigned r);
        return (r + 1) % NREQ;
    endfunction

    function automatic bit res_is_free(int unsigned d);
        return !res_taken[d] && arb_now >= res_free_at[d];
    endfunction

    function automatic bit pair_ready(int unsigned r);
        if (r == right_of(r))
            return 0;
        return res_is_free(r) && res_is_free(right_of(r));
    endfunction

    function automatic bit outranks(int unsigned a, int unsigned b);
        if (arb_edf && req_deadline[a] != req_deadline[b])
            return req_deadline[a] < req_deadline[b];
        return req_seq[a] < req_seq[b];
    endfunction

    function automatic bit beats_rival(int unsigned self, int unsigned rival);
        if (rival == self || !req_waiting[rival] || !pair_ready(rival))
            return 1;
        return outranks(self, rival);
    endfunction

    function automatic bit may_seize(int unsigned r);
        if (!pair_ready(r))
            return 0;
        return beats_rival(r, (r + NREQ - 1) % NREQ) && beats_rival(r, right_of(r));
    endfunction

    task automatic reset_arbiter_model();
        arb_edf = 0;
        arb_burnout = 0;
        arb_cooldown = 0;
        arb_now = 0;
        arb_running = 1;
        seq_counter = 0;
        for (int i = 0; i < NREQ; i++)
        begin
            res_taken[i] = 0;
            res_free_at[i] = 0;
            req_waiting[i] = 0;
            req_deadline[i] = 0;
            req_seq[i] = 0;
        end
    endtask

    // work out the grants and refusals one word causes, append to pending_grants
    task automatic predict_grants(input in_word_t w, output int unsigned count);
        out_word_t   got [$];
        out_word_t   g;
        int unsigned r;
        bit          again;
        r = w.requester;
        case (opcode_t'(w.opcode))
            OP_TICK: arb_now = arb_now + 1;
            OP_REQUEST:
                if (r < NREQ)
                begin
                    req_seq[r] = seq_counter;
                    seq_counter = seq_counter + 1;
                    req_deadline[r] = w.compile_start + arb_burnout;
                    req_waiting[r] = 1;
                    if (!arb_running)
                    begin
                        req_waiting[r] = 0;
                        g = '{who: r[2:0], granted: 1'b0, grant_time: arb_now, last: 1'b0};
                        got.push_back(g);
                    end
                end
            OP_RELEASE:
                if (r < NREQ)
                begin
                    res_taken[r] = 0;
                    res_free_at[r] = arb_now + arb_cooldown;
                    res_taken[right_of(r)] = 0;
                    res_free_at[right_of(r)] = arb_now + arb_cooldown;
                end
            default:
            begin
                arb_running = 0;
                for (int i = 0; i < NREQ; i++)
                    if (req_waiting[i])
                    begin
                        req_waiting[i] = 0;
                        g = '{who: i[2:0], granted: 1'b0, grant_time: arb_now, last: 1'b0};
                        got.push_back(g);
                    end
            end
        endcase
        if (arb_running)
        begin
            again = 1;
            while (again)
            begin
                again = 0;
                for (int i = 0; i < NREQ; i++)
                    if (req_waiting[i] && may_seize(i))
                    begin
                        req_waiting[i] = 0;
                        res_taken[i] = 1;
                        res_taken[right_of(i)] = 1;
                        g = '{who: i[2:0], granted: 1'b1, grant_time: arb_now, last: 1'b0};
                        got.push_back(g);
                        again = 1;
                    end
            end
        end
        count = got.size();
        if (count > 0)
            got[count - 1].last = 1'b1;
        foreach (got[k])
            pending_grants.push_back(got[k]);
    endtask

    initial
    begin
        clk = 0;
        forever #5 clk = ~clk;
    end

    // compare every result word with the oldest expectation
    always @(posedge clk)
    begin
        if (rst_n && result_valid)
        begin
            if (pending_grants.size() == 0)
            begin
                $error("unexpected result word: who %0d", result.who);
                fail_count++;
            end
            else
            begin
                out_word_t e;
                e = pending_grants.pop_front();
                if (result.who !== e.who)
                begin
                    $error("who: expected %0d, got %0d", e.who, result.who);
                    fail_count++;
                end
                if (result.granted !== e.granted)
                begin
                    $error("granted: expected %0d, got %0d", e.granted, result.granted);
                    fail_count++;
                end
                if (result.grant_time !== e.grant_time)
                begin
                    $error("grant_time: expected %0d, got %0d", e.grant_time, result.grant_time);
                    fail_count++;
                end
                if (result.last !== e.last)
                begin
                    $error("last: expected %0d, got %0d", e.last, result.last);
                    fail_count++;
                end
            end
        end
    end

    // watchdog: cycles with no word accepted, no result and no register access
    always @(posedge clk)
    begin
        if ((start && !busy) || result_valid || (psel && penable))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("status: fail");
            $finish;
        end
    end

    task automatic write_reg(input reg_index_t idx, input logic [31:0] value);
        psel    <= 1;
        penable <= 0;
        pwrite  <= 1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        psel    <= 0;
        penable <= 0;
        pwrite  <= 0;
        case (idx)
            REG_RANK_MODE: arb_edf = value[0];
            REG_BURNOUT:   arb_burnout = {16'd0, value[15:0]};
            default:       arb_cooldown = {16'd0, value[15:0]};
        endcase
    endtask

    // wait for all expected words, then let an in-flight scan finish
    task automatic drain();
        while (pending_grants.size() != 0)
            @(posedge clk);
        repeat (4 * NREQ + 4)
            @(posedge clk);
    endtask

    // hand one word over; start held high across back-to-back words
    task automatic send_word(input in_word_t w, output int unsigned count);
        int unsigned gap;
        if (allow_gaps && $urandom_range(0, 5) == 0)
        begin
            gap = $urandom_range(1, 19);
            start <= 0;
            repeat (gap)
                @(posedge clk);
        end
        start   <= 1;
        in_word <= w;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        predict_grants(w, count);
    endtask

    task automatic release_start();
        start <= 0;
        @(posedge clk);
    endtask

    function automatic in_word_t make_word(opcode_t op, int unsigned r, logic [31:0] cs);
        in_word_t w;
        w.opcode = op;
        w.requester = r[2:0];
        w.compile_start = cs;
        return w;
    endfunction

    function automatic in_word_t random_word(bit stop_ok);
        int unsigned pick;
        pick = $urandom_range(0, 99);
        if (pick < 35)
            return make_word(OP_TICK, $urandom_range(0, 7), $urandom());
        else if (pick < 70)
            return make_word(OP_REQUEST, $urandom_range(0, 7),
                             $urandom_range(0, 3) == 0 ? $urandom() : $urandom_range(0, 40));
        else if (pick < 99 || !stop_ok)
            return make_word(OP_RELEASE, $urandom_range(0, 7), $urandom());
        return make_word(OP_STOP, $urandom_range(0, 7), $urandom());
    endfunction

    initial
    begin
        stim_row_t   rows [$];
        int unsigned n;
        int unsigned before_len;
        out_word_t   head;

        rst_n = 0;
        start = 0;
        in_word = '0;
        psel = 0;
        penable = 0;
        pwrite = 0;
        paddr = '0;
        pwdata = '0;
        fail_count = 0;
        idle_cycles = 0;
        allow_gaps = 0;
        reset_arbiter_model();
        repeat (2)
            @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // directed table: reset state, extremes, contention
        rows.push_back('{make_word(OP_REQUEST, 0, 32'hFFFF_FFFF), 1,
                         '{who: 3'd0, granted: 1'b1, grant_time: 32'd0, last: 1'b1}});
        rows.push_back('{make_word(OP_REQUEST, 1, 32'd0), 0, '0});
        rows.push_back('{make_word(OP_REQUEST, 7, 32'd5), 0, '0});
        rows.push_back('{make_word(OP_RELEASE, 0, 32'hFFFF_FFFF), 0, '0});
        rows.push_back('{make_word(OP_TICK, 7, 32'hAAAA_5555), 0, '0});
        rows.push_back('{make_word(OP_REQUEST, 3, 32'h5555_AAAA), 0, '0});
        rows.push_back('{make_word(OP_REQUEST, 4, 32'd1), 0, '0});
        rows.push_back('{make_word(OP_REQUEST, 3, 32'd2), 0, '0});
        rows.push_back('{make_word(OP_RELEASE, 3, 32'd0), 0, '0});
        rows.push_back('{make_word(OP_RELEASE, 5, 32'd0), 0, '0});
        rows.push_back('{make_word(OP_RELEASE, 7, 32'd0), 0, '0});
        rows.push_back('{make_word(OP_TICK, 0, 32'd0), 0, '0});
        foreach (rows[k])
        begin
            before_len = pending_grants.size();
            send_word(rows[k].word, n);
            if (rows[k].has_check)
            begin
                head = pending_grants[before_len];
                if (n == 0 || head !== rows[k].first_grant)
                begin
                    $error("directed row %0d: predictor disagrees with table", k);
                    fail_count++;
                end
            end
        end
        release_start();
        drain();

        // edf with cooldown, burnout at its maximum
        write_reg(REG_RANK_MODE, 32'd1);
        write_reg(REG_BURNOUT, 32'hFFFF);
        write_reg(REG_COOLDOWN, 32'd3);
        for (int i = 0; i < NREQ; i++)
            send_word(make_word(OP_RELEASE, i, 0), n);
        for (int i = 0; i < NREQ; i++)
            send_word(make_word(OP_REQUEST, i, $urandom_range(0, 3)), n);
        repeat (4)
            send_word(make_word(OP_TICK, 0, 0), n);
        release_start();
        drain();

        // random phases over several register settings
        allow_gaps = 1;
        for (int phase = 0; phase < 4; phase++)
        begin
            write_reg(REG_RANK_MODE, {31'd0, phase[0]});
            write_reg(REG_BURNOUT, phase == 3 ? 32'h0000_FFFF : $urandom_range(0, 20));
            write_reg(REG_COOLDOWN, phase == 2 ? 32'h0000_FFFF : $urandom_range(0, 4));
            for (int k = 0; k < RANDOM_WORDS / 4; k++)
            begin
                if (phase == 3 && k > RANDOM_WORDS / 8)
                    allow_gaps = 0;
                send_word(random_word(phase == 3 && k > RANDOM_WORDS / 5), n);
            end
            release_start();
            drain();
        end

        // after stop: requests are refused at once, stop refuses nothing
        send_word(make_word(OP_STOP, 0, 0), n);
        send_word(make_word(OP_REQUEST, 2, 32'd9), n);
        send_word(make_word(OP_RELEASE, 6, 32'd0), n);
        send_word(make_word(OP_STOP, 5, 32'd0), n);
        release_start();
        drain();

        if (fail_count == 0 && pending_grants.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

### files.f
hdl/rpra_pkg.sv
hdl/rpra_cell.sv
hdl/ring_pair_resource_arbiter_top.sv
hdl/rpra_checker.sv
dv/ring_pair_resource_arbiter_top_tb.sv
